[hdl/pps_pkg.sv]
`timescale 1ns / 1ps

package pps_pkg;

    localparam int CLK_W    = 28;
    localparam int TGT_W    = 20;
    localparam int DUTY_W   = 8;
    localparam int IDX_W    = 3;
    localparam int TOP_W    = 8;
    localparam int DIV_W    = 30;
    localparam int SHIFT_W  = 4;
    localparam int MAX_PERIOD_DEF = 256;
    localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(120000000);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(7);

    typedef struct packed {
        logic capture;
        logic start_period;
        logic start_achieved;
        logic eval;
        logic next_index;
        logic commit;
        logic load_result;
    } pps_cmd_t;

    typedef struct packed {
        logic op;
        logic target_zero;
        logic div_busy;
        logic period_fit;
        logic last_index;
    } pps_status_t;

    // log2 of the prescaler divisors 1, 2, 4, 8, 16, 64, 256, 1024
    function automatic logic [SHIFT_W-1:0] shift_of(input logic [IDX_W-1:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd1;
            3'd2:    s = 4'd2;
            3'd3:    s = 4'd3;
            3'd4:    s = 4'd4;
            3'd5:    s = 4'd6;
            3'd6:    s = 4'd8;
            3'd7:    s = 4'd10;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

[hdl/pwm_prescaler_period_solver.sv]
`timescale 1ns / 1ps

// channel   | handshake             | beat fields
// ----------+-----------------------+-------------------------------------------
// request   | in_valid / in_stall   | operation, target_hz, duty_level
// result    | out_valid / out_stall | ok, divider_index, period_top, compare_value
// config    | cfg_wr_en             | cfg_wr_data (clock_hz)
//
// one request at a time; a duty request or a zero frequency skips the divider and goes to commit
// a frequency request walks the eight divisors through one shared 30-step divider,
// with a rounded period division per divisor and an achieved division if that period fits
// at most seven divisors can fit
// a finished result waits in the output register while the next request is accepted
// reset loads clock_hz = 120000000 and clears the stored setting and duty
module pwm_prescaler_period_solver #(
    parameter int MAX_PERIOD = pps_pkg::MAX_PERIOD_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [pps_pkg::CLK_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       operation,
    input  logic [pps_pkg::TGT_W-1:0]  target_hz,
    input  logic [pps_pkg::DUTY_W-1:0] duty_level,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       ok,
    output logic [pps_pkg::IDX_W-1:0]  divider_index,
    output logic [pps_pkg::TOP_W-1:0]  period_top,
    output logic [pps_pkg::TOP_W-1:0]  compare_value
);
    import pps_pkg::*;

    pps_cmd_t    cmd;
    pps_status_t status;

    pps_control u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pps_datapath #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .operation     (operation),
        .target_hz     (target_hz),
        .duty_level    (duty_level),
        .cmd           (cmd),
        .status        (status),
        .ok            (ok),
        .divider_index (divider_index),
        .period_top    (period_top),
        .compare_value (compare_value)
    );

endmodule

[hdl/pps_divider.sv]
`timescale 1ns / 1ps

module pps_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pps_pkg::DIV_W-1:0] num,
    input  logic [pps_pkg::DIV_W-1:0] den,
    output logic                     busy,
    output logic [pps_pkg::DIV_W-1:0] quotient
);
    import pps_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   partial;
    logic [DIV_W:0]   diff;

    assign partial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = partial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (partial >= {1'b0, den_reg})
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hdl/pps_datapath.sv]
`timescale 1ns / 1ps

module pps_datapath #(
    parameter int MAX_PERIOD = pps_pkg::MAX_PERIOD_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [pps_pkg::CLK_W-1:0]  cfg_wr_data,
    input  logic                       operation,
    input  logic [pps_pkg::TGT_W-1:0]  target_hz,
    input  logic [pps_pkg::DUTY_W-1:0] duty_level,
    input  pps_pkg::pps_cmd_t          cmd,
    output pps_pkg::pps_status_t       status,
    output logic                       ok,
    output logic [pps_pkg::IDX_W-1:0]  divider_index,
    output logic [pps_pkg::TOP_W-1:0]  period_top,
    output logic [pps_pkg::TOP_W-1:0]  compare_value
);
    import pps_pkg::*;

    localparam int PER_W = $clog2(MAX_PERIOD + 1);
    localparam int PROD_W = DUTY_W + TOP_W;

    logic [CLK_W-1:0]  clock_reg;
    logic              op_reg;
    logic [TGT_W-1:0]  target_reg;
    logic [DUTY_W-1:0] duty_in_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              found_reg;
    logic [DIV_W-1:0]  best_err_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [PER_W-1:0]  best_per_reg;
    logic [PER_W-1:0]  cand_per_reg;
    logic [TOP_W-1:0]  top_reg;
    logic [IDX_W-1:0]  divider_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic              valid_reg;
    logic              ok_reg;
    logic [IDX_W-1:0]  div_out_reg;
    logic [TOP_W-1:0]  top_out_reg;
    logic [TOP_W-1:0]  cmp_out_reg;

    logic [SHIFT_W-1:0] shift;
    logic [DIV_W-1:0]   denom;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   div_den;
    logic [DIV_W-1:0]   quotient;
    logic               div_busy;
    logic [DIV_W-1:0]   err;
    logic [DIV_W-1:0]   target_ext;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    scaled;

    assign shift      = shift_of(idx_reg);
    assign target_ext = DIV_W'(target_reg);
    assign denom      = target_ext << shift;

    // period division rounds; achieved division divides by divisor * period
    always_comb
    begin
        if (cmd.start_achieved)
        begin
            div_num = DIV_W'(clock_reg);
            div_den = DIV_W'(quotient[PER_W-1:0]) << shift;
        end
        else
        begin
            div_num = DIV_W'(clock_reg) + (denom >> 1);
            div_den = denom;
        end
    end

    pps_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_period | cmd.start_achieved),
        .num      (div_num),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign err = (quotient > target_ext) ? quotient - target_ext : target_ext - quotient;

    // x / 255 for 16-bit x
    assign prod   = PROD_W'(duty_reg) * PROD_W'(top_reg);
    assign scaled = (PROD_W + 1)'(prod) + (PROD_W + 1)'(1) + (PROD_W + 1)'(prod >> 8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg   <= CLOCK_RESET;
            top_reg     <= '0;
            divider_reg <= '0;
            duty_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                clock_reg <= cfg_wr_data;
            if (cmd.commit)
            begin
                if (op_reg)
                    duty_reg <= duty_in_reg;
                else if (found_reg)
                begin
                    top_reg     <= TOP_W'(best_per_reg - PER_W'(1));
                    divider_reg <= best_idx_reg;
                    valid_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= operation;
            target_reg  <= target_hz;
            duty_in_reg <= duty_level;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
        end
        else if (cmd.next_index)
            idx_reg <= idx_reg + IDX_W'(1);
        if (cmd.start_achieved)
            cand_per_reg <= quotient[PER_W-1:0];
        if (cmd.eval && (!found_reg || err < best_err_reg))
        begin
            found_reg    <= 1'b1;
            best_err_reg <= err;
            best_idx_reg <= idx_reg;
            best_per_reg <= cand_per_reg;
        end
        if (cmd.load_result)
        begin
            ok_reg      <= op_reg ? valid_reg : found_reg;
            div_out_reg <= divider_reg;
            top_out_reg <= top_reg;
            cmp_out_reg <= scaled[PROD_W-1:8];
        end
    end

    assign status.op          = op_reg;
    assign status.target_zero = (target_reg == '0);
    assign status.div_busy    = div_busy;
    assign status.period_fit  = (quotient != '0) && (quotient <= DIV_W'(MAX_PERIOD));
    assign status.last_index  = (idx_reg == LAST_IDX);

    assign ok            = ok_reg;
    assign divider_index = div_out_reg;
    assign period_top    = top_out_reg;
    assign compare_value = cmp_out_reg;

endmodule

[hdl/pps_control.sv]
`timescale 1ns / 1ps

module pps_control (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  pps_pkg::pps_status_t status,
    output pps_pkg::pps_cmd_t    cmd
);
    import pps_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_PWAIT  = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_AWAIT  = 3'd5;
    localparam logic [2:0] S_EVAL   = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       result_reg, result_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall = (state_reg != S_IDLE) || result_reg;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // result_reg marks a finished item waiting for the output register
    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (result_reg && out_free)
        begin
            cmd.load_result = 1'b1;
            out_valid_next  = 1'b1;
            result_next     = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.op || status.target_zero)
                    state_next = S_COMMIT;
                else
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.start_period = 1'b1;
                state_next       = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (!status.div_busy)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.period_fit)
                begin
                    cmd.start_achieved = 1'b1;
                    state_next         = S_AWAIT;
                end
                else if (status.last_index)
                    state_next = S_COMMIT;
                else
                begin
                    cmd.next_index = 1'b1;
                    state_next     = S_START;
                end
            end
            S_AWAIT:
            begin
                if (!status.div_busy)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.last_index)
                    state_next = S_COMMIT;
                else
                begin
                    cmd.next_index = 1'b1;
                    state_next     = S_START;
                end
            end
            S_COMMIT:
            begin
                cmd.commit  = 1'b1;
                result_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DECIDE)
        else $error("accepted beat did not enter decode");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_period || cmd.start_achieved) |-> !status.div_busy)
        else $error("divider started while busy");

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(result_reg))
        else $error("result beat raised without a finished item");

    a_eval_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> $past(state_reg) == S_AWAIT)
        else $error("evaluation without achieved division");

    a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit && result_reg || cmd.load_result)
        else $error("commit not followed by a pending result");

    a_code_unused: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !cmd.eval)
        else $error("evaluation in idle");

endmodule
